// ===== hw/rtl/trdor_pkg.sv =====
// Shared types, constants and helpers for the torus dimension-order route block.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
package trdor_pkg;

   // Torus shape limits.
   localparam int MAX_DIMS  = 4;
   localparam int COORD_BITS = 8;

   // Fixed field widths of the interface.
   localparam int WORD_BITS    = 32;
   localparam int NUM_DIMS_W   = 3;
   localparam int SIZE_REG_W   = 8;
   localparam int NUM_SIZE_REGS = 4;
   localparam int AXIS_W       = 2;
   localparam int CSR_IDX_W    = 3;

   // Derived widths.
   localparam int DIM_IDX_W = $clog2(MAX_DIMS + 1);
   localparam int SIZE_W    = (COORD_BITS + 1 > SIZE_REG_W + 1) ? COORD_BITS + 1
                                                                 : SIZE_REG_W + 1;

   // Configuration register map.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_DIMS   = 3'd0,
      CSR_SIZE_DIM0  = 3'd1,
      CSR_SIZE_DIM1  = 3'd2,
      CSR_SIZE_DIM2  = 3'd3,
      CSR_SIZE_DIM3  = 3'd4,
      CSR_OWN_COORDS = 3'd5
   } csr_index_type;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [SIZE_W-1:0]     size_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] source_coords;
      logic [WORD_BITS-1:0] dest_coords;
   } req_type;

   typedef struct packed {
      logic              on_route;
      logic              recv_valid;
      logic [AXIS_W-1:0] recv_dim;
      logic              recv_negative;
      logic              send_valid;
      logic [AXIS_W-1:0] send_dim;
      logic              send_negative;
   } rsp_type;

   // Per-dimension compare results handed to the decision logic.
   typedef struct packed {
      logic eq_src;  // own coordinate equals the source coordinate
      logic eq_dst;  // own coordinate equals the destination coordinate
      logic up;      // the shorter way from source to destination is the plus way
      logic seg;     // own coordinate lies on that walk
   } dim_flags_type;

   // Extracts the coordinate of dimension d; fields past the word read as zero.
   function automatic coord_type coord_of(input logic [WORD_BITS-1:0] word, input int d);
      logic [WORD_BITS-1:0] shifted;
      shifted = (d * COORD_BITS >= WORD_BITS) ? '0 : (word >> (d * COORD_BITS));
      return shifted[COORD_BITS-1:0];
   endfunction

endpackage

// ===== hw/rtl/trdor_csr.sv =====
// Configuration registers of the torus route block: dimension count, ring sizes, own position.
// Depends on trdor_pkg.
module trdor_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   input  logic [trdor_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [trdor_pkg::WORD_BITS-1:0]         csr_wdata,
   output logic [trdor_pkg::DIM_IDX_W-1:0]         num_dims_eff,
   output trdor_pkg::size_type [trdor_pkg::MAX_DIMS-1:0] ring_size,
   output logic [trdor_pkg::WORD_BITS-1:0]         own_coords
);

   logic [trdor_pkg::NUM_DIMS_W-1:0] num_dims_ff, num_dims_in;
   logic [trdor_pkg::SIZE_REG_W-1:0] size_ff [trdor_pkg::NUM_SIZE_REGS];
   logic [trdor_pkg::SIZE_REG_W-1:0] size_in [trdor_pkg::NUM_SIZE_REGS];
   logic [trdor_pkg::WORD_BITS-1:0]  own_ff, own_in;

   always_comb begin
      num_dims_in = num_dims_ff;
      own_in      = own_ff;
      for (int k = 0; k < trdor_pkg::NUM_SIZE_REGS; k++) begin
         size_in[k] = size_ff[k];
      end
      if (csr_valid) begin
         unique case (trdor_pkg::csr_index_type'(csr_index))
            trdor_pkg::CSR_NUM_DIMS:   num_dims_in = csr_wdata[trdor_pkg::NUM_DIMS_W-1:0];
            trdor_pkg::CSR_SIZE_DIM0:  size_in[0]  = csr_wdata[trdor_pkg::SIZE_REG_W-1:0];
            trdor_pkg::CSR_SIZE_DIM1:  size_in[1]  = csr_wdata[trdor_pkg::SIZE_REG_W-1:0];
            trdor_pkg::CSR_SIZE_DIM2:  size_in[2]  = csr_wdata[trdor_pkg::SIZE_REG_W-1:0];
            trdor_pkg::CSR_SIZE_DIM3:  size_in[3]  = csr_wdata[trdor_pkg::SIZE_REG_W-1:0];
            trdor_pkg::CSR_OWN_COORDS: own_in      = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff <= trdor_pkg::NUM_DIMS_W'(trdor_pkg::MAX_DIMS);
         own_ff      <= '0;
         for (int k = 0; k < trdor_pkg::NUM_SIZE_REGS; k++) begin
            size_ff[k] <= trdor_pkg::SIZE_REG_W'(1);
         end
      end else begin
         num_dims_ff <= num_dims_in;
         own_ff      <= own_in;
         for (int k = 0; k < trdor_pkg::NUM_SIZE_REGS; k++) begin
            size_ff[k] <= size_in[k];
         end
      end
   end

   // A count of zero acts as one; counts above the limit act as the limit.
   always_comb begin
      if (num_dims_ff == '0) begin
         num_dims_eff = trdor_pkg::DIM_IDX_W'(1);
      end else if (32'(num_dims_ff) > trdor_pkg::MAX_DIMS) begin
         num_dims_eff = trdor_pkg::DIM_IDX_W'(trdor_pkg::MAX_DIMS);
      end else begin
         num_dims_eff = trdor_pkg::DIM_IDX_W'(num_dims_ff);
      end
   end

   // Dimensions without a size register have a full ring of 2^COORD_BITS.
   for (genvar d = 0; d < trdor_pkg::MAX_DIMS; d++) begin : g_size
      if (d < trdor_pkg::NUM_SIZE_REGS) begin : g_reg
         assign ring_size[d] = trdor_pkg::SIZE_W'(size_ff[d]);
      end else begin : g_full
         assign ring_size[d] = trdor_pkg::SIZE_W'(1) << trdor_pkg::COORD_BITS;
      end
   end

   assign own_coords = own_ff;

endmodule

// ===== hw/rtl/trdor_dim.sv =====
// Per-dimension ring compare: travel direction and whether this node sits on the walk.
// Depends on trdor_pkg.
module trdor_dim (
   input  trdor_pkg::coord_type     src,
   input  trdor_pkg::coord_type     dst,
   input  trdor_pkg::coord_type     own,
   input  trdor_pkg::size_type      size,
   output trdor_pkg::dim_flags_type flags
);

   logic                          direct_up;
   logic [trdor_pkg::COORD_BITS-1:0] span;
   trdor_pkg::size_type           span_x2;
   logic                          up;

   always_comb begin
      direct_up = (dst >= src);
      span      = direct_up ? (dst - src) : (src - dst);
      span_x2   = trdor_pkg::SIZE_W'({span, 1'b0});
      // Going the wrapping way is shorter when twice the distance exceeds the ring.
      up        = (span_x2 > size) ? !direct_up : direct_up;

      flags.eq_src = (own == src);
      flags.eq_dst = (own == dst);
      flags.up     = up;
      if (up) begin
         flags.seg = (src <= dst) ? (own >= src && own <= dst) : (own >= src || own <= dst);
      end else begin
         flags.seg = (src >= dst) ? (own <= src && own >= dst) : (own <= src || own >= dst);
      end
   end

endmodule

// ===== hw/rtl/trdor_decide.sv =====
// Route decision: combines per-dimension flags into the receive and send result.
// Depends on trdor_pkg.
module trdor_decide (
   input  logic [trdor_pkg::DIM_IDX_W-1:0]                num_dims_eff,
   input  trdor_pkg::dim_flags_type [trdor_pkg::MAX_DIMS-1:0] flags,
   output trdor_pkg::rsp_type                             rsp
);

   logic [trdor_pkg::DIM_IDX_W-1:0] leg;
   logic [trdor_pkg::DIM_IDX_W-1:0] ax;
   logic on, is_src, leg_up, leg_seg, ax_up, has_leg;

   always_comb begin
      // First dimension (lowest) still to be corrected at this node.
      leg = num_dims_eff;
      for (int d = trdor_pkg::MAX_DIMS - 1; d >= 0; d--) begin
         if (trdor_pkg::DIM_IDX_W'(d) < num_dims_eff && !flags[d].eq_dst) begin
            leg = trdor_pkg::DIM_IDX_W'(d);
         end
      end
      has_leg = (leg < num_dims_eff);

      // Highest dimension already moved away from the source is the arrival axis.
      ax      = '0;
      is_src  = 1'b1;
      on      = 1'b1;
      leg_up  = 1'b0;
      leg_seg = 1'b0;
      ax_up   = 1'b0;
      for (int d = 0; d < trdor_pkg::MAX_DIMS; d++) begin
         if (trdor_pkg::DIM_IDX_W'(d) < num_dims_eff && !flags[d].eq_src) begin
            ax     = trdor_pkg::DIM_IDX_W'(d);
            is_src = 1'b0;
            if (trdor_pkg::DIM_IDX_W'(d) > leg) begin
               on = 1'b0;
            end
         end
      end
      for (int d = 0; d < trdor_pkg::MAX_DIMS; d++) begin
         if (trdor_pkg::DIM_IDX_W'(d) == leg) begin
            leg_up  = flags[d].up;
            leg_seg = flags[d].seg;
         end
         if (trdor_pkg::DIM_IDX_W'(d) == ax) begin
            ax_up = flags[d].up;
         end
      end
      if (has_leg && !leg_seg) begin
         on = 1'b0;
      end

      rsp = '0;
      if (on) begin
         rsp.on_route = 1'b1;
         if (!is_src) begin
            rsp.recv_valid    = 1'b1;
            rsp.recv_dim      = ax[trdor_pkg::AXIS_W-1:0];
            rsp.recv_negative = ax_up;
         end
         if (has_leg) begin
            rsp.send_valid    = 1'b1;
            rsp.send_dim      = leg[trdor_pkg::AXIS_W-1:0];
            rsp.send_negative = !leg_up;
         end
      end
   end

endmodule

// ===== hw/rtl/torus_dimension_order_route.sv =====
// Top level of the torus dimension-order route block: request register, route logic and
// result register. Depends on trdor_pkg, trdor_csr, trdor_dim and trdor_decide.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    trdor_pkg::req_type (source, destination)
//   rsp_      out        rsp_valid/rsp_ready    trdor_pkg::rsp_type (route decision)
//   csr_      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// An accepted request is held in the request register while the route logic works on it,
// and the result register takes the decision once it is empty or its result is taken. A
// new request can be accepted every cycle while the result register is empty or its result
// is taken. Reset is synchronous and active high; it empties both stages and returns the
// configuration registers to their defaults. When the result is not taken, the request
// register still fills once, then req_ready drops until rsp_ready returns. csr_ready is always high.
module torus_dimension_order_route (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  trdor_pkg::req_type              req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output trdor_pkg::rsp_type              rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [trdor_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [trdor_pkg::WORD_BITS-1:0] csr_wdata
);

   logic                                          s1_valid_ff, s1_valid_in;
   trdor_pkg::req_type                            s1_req_ff, s1_req_in;
   logic                                          out_valid_ff, out_valid_in;
   trdor_pkg::rsp_type                            out_rsp_ff, out_rsp_in;
   logic                                          req_accept, out_load;
   logic [trdor_pkg::DIM_IDX_W-1:0]               num_dims_eff;
   trdor_pkg::size_type [trdor_pkg::MAX_DIMS-1:0] ring_size;
   logic [trdor_pkg::WORD_BITS-1:0]               own_coords;
   trdor_pkg::dim_flags_type [trdor_pkg::MAX_DIMS-1:0] flags;
   trdor_pkg::rsp_type                            rsp_next;

   // Configuration is always accepted; the user must write it only while the block is idle (unchecked).
   assign csr_ready = 1'b1;

   trdor_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .num_dims_eff (num_dims_eff),
      .ring_size    (ring_size),
      .own_coords   (own_coords)
   );

   // One ring compare per dimension, all working in parallel on the registered request.
   for (genvar d = 0; d < trdor_pkg::MAX_DIMS; d++) begin : g_dim
      trdor_dim u_dim (
         .src   (trdor_pkg::coord_of(s1_req_ff.source_coords, d)),
         .dst   (trdor_pkg::coord_of(s1_req_ff.dest_coords, d)),
         .own   (trdor_pkg::coord_of(own_coords, d)),
         .size  (ring_size[d]),
         .flags (flags[d])
      );
   end

   trdor_decide u_decide (
      .num_dims_eff (num_dims_eff),
      .flags        (flags),
      .rsp          (rsp_next)
   );

   // With a request held, the result register loads when empty or being drained this cycle;
   // the request register can then take a new request in the same cycle.
   assign out_load   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || out_load;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      s1_req_in = req_accept ? req_payload : s1_req_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      out_rsp_in = out_load ? rsp_next : out_rsp_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff  <= s1_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_rsp_ff;

   // A node that receives or sends must be on the route.
   a_dir_on_route: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.recv_valid || rsp_payload.send_valid)
      |-> rsp_payload.on_route)
      else $error("receive or send reported off the route");

   // An unused direction reports a zero axis and polarity.
   a_idle_dir_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.recv_valid || (rsp_payload.recv_dim == '0 &&
                     !rsp_payload.recv_negative)) &&
                    (rsp_payload.send_valid || (rsp_payload.send_dim == '0 &&
                     !rsp_payload.send_negative)))
      else $error("unused direction carries a nonzero axis or polarity");

   // A stalled result with a full request register must hold off new requests.
   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request accepted while both stages are held");

   // A request in the request register reaches the result register once drained.
   a_load_moves: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid)
      else $error("loaded result not presented");

endmodule

// ===== tb/sv/torus_route_checker.sv =====
`timescale 1ns / 100ps
// Route decision checker: follows the request, result and register channels, predicts each
// route decision and compares it field by field with the block's result.
// Depends on trdor_pkg for the request, result and register index types.
module torus_route_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  trdor_pkg::req_type              req_payload,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  trdor_pkg::rsp_type              rsp_payload,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [trdor_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [trdor_pkg::WORD_BITS-1:0] csr_wdata,
   output int                              fail_count,
   output int                              outstanding
);

   // Shadow copy of the configuration registers.
   logic [trdor_pkg::NUM_DIMS_W-1:0]                                dims_reg;
   logic [trdor_pkg::NUM_SIZE_REGS-1:0][trdor_pkg::SIZE_REG_W-1:0] ring_lens;
   logic [trdor_pkg::WORD_BITS-1:0]                                 own_word;

   // Predicted decisions, oldest first.
   trdor_pkg::rsp_type pending_decisions[$];

   // True when the shorter way from from_c to to_c is the plus way; a tie goes direct.
   function automatic logic heads_plus(input trdor_pkg::coord_type from_c,
                                       input trdor_pkg::coord_type to_c,
                                       input logic [trdor_pkg::SIZE_REG_W-1:0] len);
      logic                           up;
      logic [trdor_pkg::COORD_BITS:0] span;
      up = (to_c >= from_c);
      span = {1'b0, up ? to_c - from_c : from_c - to_c};
      if ((span << 1) > {1'b0, len})
         up = !up;
      return up;
   endfunction

   function automatic logic on_walk(input trdor_pkg::coord_type from_c,
                                    input trdor_pkg::coord_type to_c,
                                    input trdor_pkg::coord_type mid, input logic up);
      if (up)
         return (from_c <= to_c) ? (mid >= from_c && mid <= to_c)
                                 : (mid >= from_c || mid <= to_c);
      return (from_c >= to_c) ? (mid <= from_c && mid >= to_c)
                              : (mid <= from_c || mid >= to_c);
   endfunction

   function automatic trdor_pkg::rsp_type predict_decision(input trdor_pkg::req_type q);
      trdor_pkg::rsp_type   d;
      int                   n, leg, last_diff, i;
      logic                 reached, at_source;
      trdor_pkg::coord_type own_c[trdor_pkg::MAX_DIMS];
      trdor_pkg::coord_type src_c[trdor_pkg::MAX_DIMS];
      trdor_pkg::coord_type dst_c[trdor_pkg::MAX_DIMS];
      d = '0;
      for (i = 0; i < trdor_pkg::MAX_DIMS; i++) begin
         own_c[i] = own_word[i*trdor_pkg::COORD_BITS +: trdor_pkg::COORD_BITS];
         src_c[i] = q.source_coords[i*trdor_pkg::COORD_BITS +: trdor_pkg::COORD_BITS];
         dst_c[i] = q.dest_coords[i*trdor_pkg::COORD_BITS +: trdor_pkg::COORD_BITS];
      end
      n = int'(dims_reg);
      if (n < 1)
         n = 1;
      if (n > trdor_pkg::MAX_DIMS)
         n = trdor_pkg::MAX_DIMS;
      // The leg is the first dimension in which this node still differs from the destination.
      leg = 0;
      while (leg < n && own_c[leg] == dst_c[leg])
         leg++;
      reached = 1'b1;
      at_source = 1'b1;
      last_diff = 0;
      for (i = 0; i < n; i++) begin
         if (own_c[i] != src_c[i]) begin
            at_source = 1'b0;
            last_diff = i;
            if (i > leg)
               reached = 1'b0;
         end
      end
      if (leg < n) begin
         if (!on_walk(src_c[leg], dst_c[leg], own_c[leg],
                      heads_plus(src_c[leg], dst_c[leg], ring_lens[leg])))
            reached = 1'b0;
      end
      if (reached) begin
         d.on_route = 1'b1;
         if (!at_source) begin
            d.recv_valid = 1'b1;
            d.recv_dim = last_diff[trdor_pkg::AXIS_W-1:0];
            d.recv_negative = heads_plus(src_c[last_diff], dst_c[last_diff],
                                         ring_lens[last_diff]);
         end
         if (leg < n) begin
            d.send_valid = 1'b1;
            d.send_dim = leg[trdor_pkg::AXIS_W-1:0];
            d.send_negative = !heads_plus(src_c[leg], dst_c[leg], ring_lens[leg]);
         end
      end
      return d;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      trdor_pkg::rsp_type want;
      if (reset) begin
         dims_reg = 3'd4;
         ring_lens = {trdor_pkg::NUM_SIZE_REGS{8'd1}};
         own_word = '0;
         pending_decisions.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (trdor_pkg::csr_index_type'(csr_index))
               trdor_pkg::CSR_NUM_DIMS:
                  dims_reg = csr_wdata[trdor_pkg::NUM_DIMS_W-1:0];
               trdor_pkg::CSR_SIZE_DIM0:
                  ring_lens[0] = csr_wdata[trdor_pkg::SIZE_REG_W-1:0];
               trdor_pkg::CSR_SIZE_DIM1:
                  ring_lens[1] = csr_wdata[trdor_pkg::SIZE_REG_W-1:0];
               trdor_pkg::CSR_SIZE_DIM2:
                  ring_lens[2] = csr_wdata[trdor_pkg::SIZE_REG_W-1:0];
               trdor_pkg::CSR_SIZE_DIM3:
                  ring_lens[3] = csr_wdata[trdor_pkg::SIZE_REG_W-1:0];
               trdor_pkg::CSR_OWN_COORDS:
                  own_word = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_decisions.size() == 0) begin
               $error("route result with no request waiting for it");
               fail_count++;
            end else begin
               want = pending_decisions.pop_front();
               check_field("on_route", want.on_route, rsp_payload.on_route);
               check_field("recv_valid", want.recv_valid, rsp_payload.recv_valid);
               check_field("recv_dim", want.recv_dim, rsp_payload.recv_dim);
               check_field("recv_negative", want.recv_negative, rsp_payload.recv_negative);
               check_field("send_valid", want.send_valid, rsp_payload.send_valid);
               check_field("send_dim", want.send_dim, rsp_payload.send_dim);
               check_field("send_negative", want.send_negative, rsp_payload.send_negative);
            end
         end
         if (req_valid && req_ready)
            pending_decisions.push_back(predict_decision(req_payload));
      end
      outstanding = pending_decisions.size();
   end

endmodule

// ===== tb/sv/torus_dimension_order_route_tb.sv =====
`timescale 1ns / 100ps
// Top of the torus dimension-order route testbench: clock, reset, request, result and
// register stimulus, and the verdict.
// Depends on trdor_pkg, the route block and torus_route_checker.
module torus_dimension_order_route_tb;

   // Each side waits up to GAP_MAX before each handshake; HOLD_CYCLES is the long result stall
   // that fills the block and pushes back on the request side.
   localparam int GAP_MAX      = 14;
   localparam int HOLD_CYCLES  = 200;
   localparam int RANDOM_ITEMS = 950;
   localparam int DRAIN_CYCLES = 4;
   // The limit lies well above the slowest correct progress between handshakes, the long stall included.
   localparam int STALL_LIMIT  = 4000;

   // How a side spaces its handshakes.
   typedef enum int {
      GAPS_NONE,
      GAPS_FULL,
      GAPS_SPARSE
   } gap_mode_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   trdor_pkg::req_type              req_payload;
   logic                            rsp_valid;
   logic                            rsp_ready;
   trdor_pkg::rsp_type              rsp_payload;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [trdor_pkg::CSR_IDX_W-1:0] csr_index;
   logic [trdor_pkg::WORD_BITS-1:0] csr_wdata;

   // Handshakes seen at the last rising edge; the drivers read these at the falling edge.
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   logic csr_taken = 1'b0;

   int           fail_count;
   int           outstanding;
   int           requests_sent;
   int           on_route_seen;
   int           settings_applied;
   int           stall_cycles;
   gap_mode_type req_mode = GAPS_NONE;
   gap_mode_type rsp_mode = GAPS_NONE;
   // Raised by the request side each time it wants a long result stall.
   int           hold_asks = 0;

   // The configuration currently in the block, used to aim requests at this node.
   logic [trdor_pkg::NUM_SIZE_REGS-1:0][trdor_pkg::SIZE_REG_W-1:0] cur_lens;
   logic [trdor_pkg::WORD_BITS-1:0]                                 cur_own;

   torus_dimension_order_route DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   torus_route_checker route_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Handshake flags, coverage counters and the watchdog. The watchdog restarts whenever any
   // channel moves something, so only a real hang can reach the limit.
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
      rsp_taken <= rsp_valid && rsp_ready;
      csr_taken <= csr_valid && csr_ready;
      if (req_valid && req_ready)
         requests_sent <= requests_sent + 1;
      if (rsp_valid && rsp_ready && rsp_payload.on_route)
         on_route_seen <= on_route_seen + 1;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("torus_dimension_order_route verification failed");
         $finish;
      end
   end

   function automatic int draw_gap(input gap_mode_type mode);
      case (mode)
         GAPS_NONE:   return 0;
         GAPS_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, GAP_MAX) : 0;
         default:     return $urandom_range(0, GAP_MAX);
      endcase
   endfunction

   // A coordinate on a ring of the given length, now and then one beyond it. A zero length
   // means any coordinate.
   function automatic trdor_pkg::coord_type pick_on_ring(
         input logic [trdor_pkg::SIZE_REG_W-1:0] len);
      if (len == 0 || $urandom_range(0, 15) == 0)
         return trdor_pkg::coord_type'($urandom_range(0, 255));
      return trdor_pkg::coord_type'($urandom_range(0, int'(len) - 1));
   endfunction

   // Offers one request after a random gap and returns at the falling edge after it was
   // accepted, with valid still high so that a back-to-back request keeps it high.
   task automatic push_route(input logic [trdor_pkg::WORD_BITS-1:0] src,
                             input logic [trdor_pkg::WORD_BITS-1:0] dst);
      int gap;
      gap = draw_gap(req_mode);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{source_coords: src, dest_coords: dst};
      do @(negedge clock); while (!req_taken);
   endtask

   // Stops offering requests and waits until every decision has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input trdor_pkg::csr_index_type idx,
                            input logic [trdor_pkg::WORD_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(negedge clock); while (!csr_taken);
   endtask

   // Writes all six registers while the block is idle. Lengths are packed dimension 3 first.
   task automatic apply_setting(
         input logic [trdor_pkg::NUM_DIMS_W-1:0]                          dims,
         input logic [trdor_pkg::NUM_SIZE_REGS-1:0][trdor_pkg::SIZE_REG_W-1:0] lens,
         input logic [trdor_pkg::WORD_BITS-1:0]                           own);
      wait_idle();
      write_reg(trdor_pkg::CSR_NUM_DIMS, trdor_pkg::WORD_BITS'(dims));
      write_reg(trdor_pkg::CSR_SIZE_DIM0, trdor_pkg::WORD_BITS'(lens[0]));
      write_reg(trdor_pkg::CSR_SIZE_DIM1, trdor_pkg::WORD_BITS'(lens[1]));
      write_reg(trdor_pkg::CSR_SIZE_DIM2, trdor_pkg::WORD_BITS'(lens[2]));
      write_reg(trdor_pkg::CSR_SIZE_DIM3, trdor_pkg::WORD_BITS'(lens[3]));
      write_reg(trdor_pkg::CSR_OWN_COORDS, own);
      csr_valid <= 1'b0;
      cur_lens = lens;
      cur_own = own;
      settings_applied++;
   endtask

   // Mostly small rings so that a fair share of requests pass through this node. Now and
   // then the dimension count is zero or above the maximum, and a ring is empty or of length 255.
   task automatic random_setting();
      logic [trdor_pkg::NUM_DIMS_W-1:0]                                dims;
      logic [trdor_pkg::NUM_SIZE_REGS-1:0][trdor_pkg::SIZE_REG_W-1:0] lens;
      logic [trdor_pkg::WORD_BITS-1:0]                                 own;
      int                                                              r, d;
      r = $urandom_range(0, 9);
      if (r == 0)
         dims = ($urandom_range(0, 1) == 0) ? 3'd0
                                            : 3'($urandom_range(trdor_pkg::MAX_DIMS + 1, 7));
      else
         dims = 3'($urandom_range(1, trdor_pkg::MAX_DIMS));
      for (d = 0; d < trdor_pkg::NUM_SIZE_REGS; d++) begin
         r = $urandom_range(0, 9);
         if (r == 0)
            lens[d] = 8'd0;
         else if (r == 1)
            lens[d] = 8'd255;
         else if (r == 2)
            lens[d] = 8'($urandom_range(1, 255));
         else
            lens[d] = 8'($urandom_range(1, 9));
         own[d*trdor_pkg::COORD_BITS +: trdor_pkg::COORD_BITS] = pick_on_ring(lens[d]);
      end
      apply_setting(dims, lens, own);
   endtask

   // Most requests share coordinates with this node in many dimensions, which is what it
   // takes to land on the route; one in ten is plain noise over the whole word.
   task automatic make_route(output logic [trdor_pkg::WORD_BITS-1:0] src,
                             output logic [trdor_pkg::WORD_BITS-1:0] dst);
      int d;
      src = $urandom;
      dst = $urandom;
      if ($urandom_range(0, 9) == 0)
         return;
      for (d = 0; d < trdor_pkg::MAX_DIMS; d++) begin
         src[d*trdor_pkg::COORD_BITS +: trdor_pkg::COORD_BITS] = ($urandom_range(0, 1) == 0)
            ? cur_own[d*trdor_pkg::COORD_BITS +: trdor_pkg::COORD_BITS]
            : pick_on_ring(cur_lens[d]);
         dst[d*trdor_pkg::COORD_BITS +: trdor_pkg::COORD_BITS] = ($urandom_range(0, 2) == 0)
            ? cur_own[d*trdor_pkg::COORD_BITS +: trdor_pkg::COORD_BITS]
            : pick_on_ring(cur_lens[d]);
      end
   endtask

   task automatic run_directed();
      // Two dimensions in use (rings of 8 and 6), this node at (3, 2); the upper bytes of
      // its coordinates are junk that must be ignored.
      req_mode = gap_mode_type'($urandom_range(0, 2));
      apply_setting(3'd2, {8'd255, 8'd0, 8'd6, 8'd8}, 32'h5A5A_0203);
      push_route(32'hC3C3_0203, 32'h1111_0206);   // this node is the source
      push_route(32'h0000_0200, 32'hFFFF_0203);   // this node is the destination
      push_route(32'h0102_0203, 32'hA0B0_0203);   // source, destination and node coincide
      push_route(32'h0000_0201, 32'h0000_0205);   // half the ring going up takes the direct way
      push_route(32'h0000_0205, 32'h0000_0201);   // the same tie going down
      push_route(32'h0000_0201, 32'h0000_0206);   // short way wraps below zero, node is off it
      push_route(32'h0000_0500, 32'h0000_0103);   // second dimension corrected, wrapping up
      push_route(32'h0000_0000, 32'hFFFF_FFFF);   // all-zero and all-one words

      // A zero dimension count acts as one. Ring 10 with the node at 0: wrapped walks cross it.
      apply_setting(3'd0, {8'd1, 8'd255, 8'd0, 8'd10}, 32'hFFFF_FF00);
      push_route(32'h0000_0008, 32'hFFFF_FF02);
      push_route(32'hFFFF_FF02, 32'h0000_0008);
      push_route(32'h0000_0000, 32'hFFFF_FFFF);   // destination beyond the ring
      push_route(32'hFFFF_FFFF, 32'h0000_0000);
      push_route(32'h1234_5600, 32'h0000_0005);   // tie from the source
      push_route(32'h0000_0005, 32'hABCD_EF00);   // tie into the destination

      // A count above the maximum acts as the maximum. An empty first ring sends every
      // nonzero distance the wrapping way, and the last ring is shorter than its coordinates.
      apply_setting(3'd7, {8'd1, 8'd3, 8'd255, 8'd0}, 32'h0102_0100);
      push_route(32'h0102_0105, 32'h0102_0100);
      push_route(32'h0102_0100, 32'h0102_0103);
      push_route(32'h0102_0100, 32'h0302_01FF);
      push_route(32'h0102_F000, 32'h0102_01F0);   // higher dimension differs from the source
      push_route(32'h0102_01FF, 32'h0103_0100);
      push_route(32'h0000_0000, 32'hFFFF_FFFF);
      push_route(32'hFFFF_FFFF, 32'h0000_0000);
      push_route(32'h0502_0100, 32'h0102_0100);   // arrives along the highest axis
      push_route(32'h0102_0100, 32'h0702_0100);   // leaves along the highest axis
   endtask

   // Result side: a random stall before each result, with the stall pattern changing every
   // couple of dozen results. When asked, it also holds off for HOLD_CYCLES in a row.
   initial begin
      int served;
      int gap;
      int holds_done;
      served = 0;
      holds_done = 0;
      rsp_ready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         if (hold_asks != holds_done) begin
            holds_done = hold_asks;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (served % 24 == 0)
            rsp_mode = gap_mode_type'($urandom_range(0, 2));
         gap = draw_gap(rsp_mode);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_taken && hold_asks == holds_done);
         served++;
      end
   end

   // Request side and verdict.
   initial begin
      logic [trdor_pkg::WORD_BITS-1:0] src, dst;
      int                              sent, phase, quota, k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      run_directed();

      // Random phases, each under its own register setting. The first two are the widest
      // and the narrowest torus; the third runs the sender flat out while the result side
      // stalls, so the block fills and drops req_ready.
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase == 0)
            apply_setting(3'd4, {trdor_pkg::NUM_SIZE_REGS{8'd255}}, $urandom);
         else if (phase == 1)
            apply_setting(3'd1, {trdor_pkg::NUM_SIZE_REGS{8'd1}}, '0);
         else
            random_setting();
         req_mode = (phase == 2) ? GAPS_NONE : gap_mode_type'($urandom_range(0, 2));
         quota = $urandom_range(50, 110);
         for (k = 0; k < quota && sent < RANDOM_ITEMS; k++) begin
            if (phase == 2 && k == 10)
               hold_asks++;
            make_route(src, dst);
            push_route(src, dst);
            sent++;
         end
         phase++;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d route requests under %0d register settings; %0d landed on this node.",
               requests_sent, settings_applied, on_route_seen);
      $display(
         "Covered clamped counts, empty and full rings, ties, wraps and a %0d-cycle stall.",
         HOLD_CYCLES);
      if (fail_count == 0 && outstanding == 0)
         $display("torus_dimension_order_route verification clean");
      else
         $display("torus_dimension_order_route verification failed");
      $finish;
   end

endmodule
